// ===== sv/integer_to_radix_ascii_unit_defines.svh =====
// assertion macros shared by the itoa checker
// expects clk and arst_n in the scope of use
`ifndef INTEGER_TO_RADIX_ASCII_UNIT_DEFINES_SVH
`define INTEGER_TO_RADIX_ASCII_UNIT_DEFINES_SVH

// clocked property, held off while reset is low
`define ITOA_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// antecedent in one cycle, consequent in the next
`define ITOA_ASSERT_NEXT(lbl, ante, cons, msg) \
	`ITOA_ASSERT_CLK(lbl, (ante) |=> (cons), msg)

`endif

// ===== sv/itoa_pkg.sv =====
// shared types, character constants and digit helpers for the itoa unit
// no dependencies
package itoa_pkg;

	typedef logic [5:0] radix_t;
	typedef logic [5:0] digit_t;
	typedef logic [6:0] char_t;

	localparam char_t  CHAR_ZERO   = 7'h30;
	localparam char_t  CHAR_A      = 7'h61;
	localparam char_t  CHAR_MINUS  = 7'h2D;
	localparam char_t  CHAR_NINE   = 7'h39;
	localparam char_t  CHAR_Z      = 7'h7A;
	localparam digit_t MAX_DIGIT   = 6'd9;
	localparam radix_t DECIMAL     = 6'd10;
	localparam radix_t RADIX_MIN   = 6'd2;
	localparam radix_t RADIX_MAX   = 6'd36;
	localparam radix_t RADIX_RESET = 6'd10;

	// clamp the register into 2..36
	function automatic radix_t eff_radix(input radix_t r);
		radix_t res;
		res = r;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end
		return res;
	endfunction

	// digit value to ascii, lower-case letters above nine
	function automatic char_t digit_to_char(input digit_t d);
		char_t c;
		if (d > MAX_DIGIT) begin
			c = char_t'(d) - char_t'(DECIMAL) + CHAR_A;
		end else begin
			c = char_t'(d) + CHAR_ZERO;
		end
		return c;
	endfunction

endpackage

// ===== sv/integer_to_radix_ascii_unit.sv =====
// itoa unit top level: integer to ascii digits in radix 2..36
// depends on itoa_pkg and itoa_ram
//
// usage
//   input channel: in_valid / in_stall / value, one signed integer per beat
//   output channel: out_valid / out_stall / char_code / last_char, one
//   ascii character per beat, most significant digit first, last_char set
//   on the final character of each number
//   config: cfg_we / cfg_wdata write the radix register (reset 10); values
//   below 2 act as 2, above 36 act as 36; write only while idle
//   radix 10 with a negative value puts a '-' first; other radices read
//   the bits as unsigned; zero gives a single '0'
// timing
//   digits come from a bit-serial restoring divider, least significant
//   digit first; each digit character then goes through the digit ram
//   read port in the ST_READ and ST_LOAD states
//   in_stall rises after the accepted beat and stays high until the last
//   character is loaded into the output register
// reset
//   arst_n clears the sequencer, the output valid and the radix (to 10)
// backpressure
//   out_stall holds the output register; the sequencer waits with it
module integer_to_radix_ascii_unit #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  itoa_pkg::radix_t              cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output itoa_pkg::char_t               char_code,
	output logic                          last_char
);

	// digit store index and digit count widths
	localparam int IDX_W = $clog2(VALUE_WIDTH);
	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_SIGN = 3'd2;
	localparam logic [2:0] ST_READ = 3'd3;
	localparam logic [2:0] ST_LOAD = 3'd4;

	logic [2:0]             state_q;
	itoa_pkg::radix_t       radix_q;    // config register
	itoa_pkg::radix_t       rdx_q;      // clamped radix for this number
	logic                   minus_q;
	logic [VALUE_WIDTH-1:0] dvd_q;      // dividend shifting out, quotient in
	itoa_pkg::digit_t       rem_q;      // partial remainder
	logic [IDX_W-1:0]       bit_q;      // divide step counter
	logic [CNT_W-1:0]       cnt_q;      // digits stored / left to send
	logic                   out_valid_q;
	itoa_pkg::char_t        char_q;
	logic                   last_q;

	logic                   in_accept;
	logic                   out_free;
	logic                   out_load;
	itoa_pkg::radix_t       rdx_in;
	logic                   neg_in;
	logic [VALUE_WIDTH-1:0] mag_in;
	logic [6:0]             trial;
	logic                   ge;
	itoa_pkg::digit_t       rem_nxt;
	logic [VALUE_WIDTH-1:0] quot_nxt;
	logic                   digit_done;
	logic [CNT_W-1:0]       cnt_m1;
	itoa_pkg::digit_t       rd_digit;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	// output register can take a new character this cycle
	assign out_free  = !out_valid_q || !out_stall;
	// a sign or a digit goes into the output register this cycle
	assign out_load  = out_free &&
		(((state_q == ST_SIGN) && minus_q) || (state_q == ST_LOAD));

	// magnitude: only radix 10 treats the value as signed
	assign rdx_in = itoa_pkg::eff_radix(radix_q);
	assign neg_in = value[VALUE_WIDTH-1] && (rdx_in == itoa_pkg::DECIMAL);
	assign mag_in = neg_in ? (~value + 1'b1) : value;

	// one restoring divide step: bring in the next dividend bit
	assign trial    = {rem_q, dvd_q[VALUE_WIDTH-1]};
	assign ge       = (trial >= {1'b0, rdx_q});
	assign rem_nxt  = ge ? 6'(trial - {1'b0, rdx_q}) : trial[5:0];
	assign quot_nxt = {dvd_q[VALUE_WIDTH-2:0], ge};

	assign digit_done = (state_q == ST_DIV) && (bit_q == IDX_W'(VALUE_WIDTH - 1));
	assign cnt_m1     = cnt_q - CNT_W'(1);

	// digits land least significant first, read back from the top
	itoa_ram #(
		.WIDTH(6),
		.DEPTH(VALUE_WIDTH)
	) u_store (
		.clk  (clk),
		.we   (digit_done),
		.waddr(cnt_q[IDX_W-1:0]),
		.wdata(rem_nxt),
		.raddr(cnt_m1[IDX_W-1:0]),
		.rdata(rd_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			radix_q     <= itoa_pkg::RADIX_RESET;
			minus_q     <= 1'b0;
			cnt_q       <= '0;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				radix_q <= cfg_wdata;
			end
			// new beat loaded, else the taken beat empties the register
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						rdx_q   <= rdx_in;
						minus_q <= neg_in;
						dvd_q   <= mag_in;
						rem_q   <= '0;
						bit_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					dvd_q <= quot_nxt;
					if (digit_done) begin
						cnt_q <= cnt_q + CNT_W'(1);
						rem_q <= '0;
						bit_q <= '0;
						// quotient zero ends extraction, zero input gives one digit
						if (quot_nxt == '0) begin
							state_q <= ST_SIGN;
						end
					end else begin
						rem_q <= rem_nxt;
						bit_q <= bit_q + IDX_W'(1);
					end
				end
				ST_SIGN: begin
					if (!minus_q) begin
						state_q <= ST_READ;
					end else if (out_free) begin
						char_q  <= itoa_pkg::CHAR_MINUS;
						last_q  <= 1'b0;
						minus_q <= 1'b0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					// ram address already points at the top digit
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (out_free) begin
						char_q  <= itoa_pkg::digit_to_char(rd_digit);
						last_q  <= (cnt_q == CNT_W'(1));
						cnt_q   <= cnt_m1;
						state_q <= (cnt_q == CNT_W'(1)) ? ST_IDLE : ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last_char = last_q;

endmodule

// ===== sv/itoa_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module itoa_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/itoa_checker.sv =====
// port-level assertions for the itoa unit, bound to the top level
// depends on itoa_pkg and integer_to_radix_ascii_unit_defines.svh
`include "integer_to_radix_ascii_unit_defines.svh"

module itoa_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_stall,
	input logic            out_valid,
	input logic            out_stall,
	input itoa_pkg::char_t char_code,
	input logic            last_char
);

	// stalled output beat holds
	`ITOA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(char_code) && $stable(last_char), "stalled output beat changed")

	// the sequencer leaves idle on a beat, so input closes right after it
	`ITOA_ASSERT_NEXT(a_in_busy, in_valid && !in_stall, in_stall, "input open right after an accepted beat")

	// only digits, lower-case letters or minus
	`ITOA_ASSERT_CLK(a_char_legal, out_valid |-> ((char_code == itoa_pkg::CHAR_MINUS) || ((char_code >= itoa_pkg::CHAR_ZERO) && (char_code <= itoa_pkg::CHAR_NINE)) || ((char_code >= itoa_pkg::CHAR_A) && (char_code <= itoa_pkg::CHAR_Z))), "illegal character")

	// a sign is never the last character
	`ITOA_ASSERT_CLK(a_minus_not_last, out_valid && (char_code == itoa_pkg::CHAR_MINUS) |-> !last_char, "minus flagged as last character")

endmodule

bind integer_to_radix_ascii_unit itoa_checker u_itoa_checker (.*);
